// File: rtl/core/eps_pkg.sv
package eps_pkg;

    // Field widths
    localparam int CountWidth    = 16;
    localparam int DataWidth     = 32;
    localparam int LimitWidth    = 15;
    localparam int PwmWidth      = 16;
    localparam int CfgIndexWidth = 2;

    localparam logic [LimitWidth-1:0] DriveLimitReset = LimitWidth'(500);

    // Fixed-point layout of the drive terms
    localparam int QShift      = 16;
    localparam int DerivShift  = 8;
    localparam int TermSatBit  = 47;
    localparam int TermWidth   = TermSatBit + 3;
    localparam int ProdWidth   = 2 * DataWidth + 1;
    localparam int DivSteps    = TermSatBit;
    localparam int DivLow      = TermSatBit - DerivShift;
    localparam int DivCntWidth = $clog2(DivSteps);
    localparam logic [TermSatBit:0] TermSat = {1'b1, {TermSatBit{1'b0}}};

    localparam int StepWidth = 4;
    typedef logic [StepWidth-1:0] step_t;

    typedef enum logic [CfgIndexWidth-1:0] {
        REG_PROP_GAIN,
        REG_INTEG_GAIN,
        REG_DERIV_GAIN,
        REG_DRIVE_LIMIT
    } cfg_reg_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_TAKE,
        OP_ERROR,
        OP_INTEG,
        OP_TERM_P,
        OP_SAVE_HI,
        OP_TERM_I,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_TERM_D,
        OP_FINISH
    } op_t;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_E_DT,
        MUL_P,
        MUL_I_HI,
        MUL_I_LO,
        MUL_D
    } mul_sel_t;

    typedef enum logic [2:0] {
        JC_NEVER,
        JC_ALWAYS,
        JC_NO_SAMPLE,
        JC_ZERO_DT,
        JC_DIV_BUSY,
        JC_OUT_BUSY
    } jump_cond_t;

    typedef struct packed {
        op_t        op;
        mul_sel_t   msel;
        jump_cond_t jc;
        step_t      target;
    } ctl_word_t;

    typedef struct packed {
        logic sample_valid;
        logic zero_dt;
        logic div_busy;
        logic out_busy;
    } seq_status_t;

endpackage

// File: rtl/core/eps_sample_if.sv
interface eps_sample_if
    import eps_pkg::*;
();
    logic                        valid;
    logic                        ready;
    logic [CountWidth-1:0]       encoder_count;
    logic signed [DataWidth-1:0] target_position;
    logic [DataWidth-1:0]        timestamp_us;

    modport source (
        output valid,
        output encoder_count,
        output target_position,
        output timestamp_us,
        input  ready
    );

    modport sink (
        input  valid,
        input  encoder_count,
        input  target_position,
        input  timestamp_us,
        output ready
    );
endinterface

// File: rtl/core/eps_result_if.sv
interface eps_result_if
    import eps_pkg::*;
();
    logic                        valid;
    logic                        ready;
    logic [PwmWidth-1:0]         pwm_compare;
    logic signed [DataWidth-1:0] position_ticks;
    logic                        drive_clamped;
    logic                        zero_interval;

    modport source (
        output valid,
        output pwm_compare,
        output position_ticks,
        output drive_clamped,
        output zero_interval,
        input  ready
    );

    modport sink (
        input  valid,
        input  pwm_compare,
        input  position_ticks,
        input  drive_clamped,
        input  zero_interval,
        output ready
    );
endinterface

// File: rtl/core/eps_seq.sv
module eps_seq
    import eps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  seq_status_t status,
    output ctl_word_t   ctl
);

    localparam step_t StepTake    = step_t'(0);
    localparam step_t StepDivStep = step_t'(8);
    localparam step_t StepFinish  = step_t'(10);

    // Control store: one word per step
    function automatic ctl_word_t program_word(input step_t s);
        ctl_word_t w;
        w = '{op: OP_NOP, msel: MUL_NONE, jc: JC_ALWAYS, target: StepTake};
        unique case (s)
            step_t'(0):  w = '{op: OP_TAKE,     msel: MUL_NONE, jc: JC_NO_SAMPLE, target: StepTake};
            step_t'(1):  w = '{op: OP_ERROR,    msel: MUL_NONE, jc: JC_NEVER,     target: StepTake};
            step_t'(2):  w = '{op: OP_NOP,      msel: MUL_E_DT, jc: JC_NEVER,     target: StepTake};
            step_t'(3):  w = '{op: OP_INTEG,    msel: MUL_P,    jc: JC_NEVER,     target: StepTake};
            step_t'(4):  w = '{op: OP_TERM_P,   msel: MUL_I_HI, jc: JC_NEVER,     target: StepTake};
            step_t'(5):  w = '{op: OP_SAVE_HI,  msel: MUL_I_LO, jc: JC_NEVER,     target: StepTake};
            step_t'(6):  w = '{op: OP_TERM_I,   msel: MUL_D,    jc: JC_NEVER,     target: StepTake};
            step_t'(7):  w = '{op: OP_DIV_INIT, msel: MUL_NONE, jc: JC_ZERO_DT,   target: StepFinish};
            step_t'(8):  w = '{op: OP_DIV_STEP, msel: MUL_NONE, jc: JC_DIV_BUSY,  target: StepDivStep};
            step_t'(9):  w = '{op: OP_TERM_D,   msel: MUL_NONE, jc: JC_NEVER,     target: StepTake};
            step_t'(10): w = '{op: OP_FINISH,   msel: MUL_NONE, jc: JC_OUT_BUSY,  target: StepFinish};
            default:     w = '{op: OP_NOP,      msel: MUL_NONE, jc: JC_ALWAYS,    target: StepTake};
        endcase
        return w;
    endfunction

    step_t step_reg;
    step_t step_next;
    logic  jump;

    assign ctl = program_word(step_reg);

    always_comb
    begin
        unique case (ctl.jc)
            JC_NEVER:     jump = 1'b0;
            JC_ALWAYS:    jump = 1'b1;
            JC_NO_SAMPLE: jump = !status.sample_valid;
            JC_ZERO_DT:   jump = status.zero_dt;
            JC_DIV_BUSY:  jump = status.div_busy;
            JC_OUT_BUSY:  jump = status.out_busy;
            default:      jump = 1'b0;
        endcase
        step_next = jump ? ctl.target : step_reg + step_t'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= StepTake;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

// File: rtl/core/encoder_position_pid_servo.sv
// Channel   Dir  Word
// sample    in   encoder_count, target_position, timestamp_us
// result    out  pwm_compare, position_ticks, drive_clamped, zero_interval
// cfg       in   cfg_we, cfg_index, cfg_data (write only)
//
// One word at a time: the next sample is accepted only after the result is loaded,
// and a zero dt skips the divider and the derivative term. The derivative
// divider takes 47 single-bit steps; all products share one 32x33 multiplier.
// A new sample is taken once the previous result sits in the output register.
// A stalled result holds the sequencer at its final step.
// Reset clears the gains, the limit (to 500), the tracking state and result valid.
module encoder_position_pid_servo
    import eps_pkg::*;
#(
    parameter int COUNTER_WIDTH = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    eps_sample_if.sink               sample,
    eps_result_if.source             result,
    input  logic                     cfg_we,
    input  logic [CfgIndexWidth-1:0] cfg_index,
    input  logic [DataWidth-1:0]     cfg_data
);

    localparam int DriveWidth = TermWidth - QShift;

    function automatic logic signed [TermWidth-1:0] sat_term(
        input logic [ProdWidth-1:0] mag,
        input logic                 neg
    );
        logic [TermWidth-1:0] m;
        m = (mag > ProdWidth'(TermSat)) ? TermWidth'(TermSat) : TermWidth'(mag);
        return neg ? -signed'(m) : signed'(m);
    endfunction

    ctl_word_t   ctl;
    seq_status_t status;

    // Configuration and tracking state
    logic signed [DataWidth-1:0]   kp_reg, ki_reg, kd_reg;
    logic [LimitWidth-1:0]         lim_reg;
    logic [COUNTER_WIDTH-1:0]      last_count_reg;
    logic signed [DataWidth-1:0]   position_reg;
    logic [DataWidth-1:0]          last_time_reg;
    logic signed [2*DataWidth-1:0] integ_reg, integ_next;
    logic signed [DataWidth-1:0]   prev_err_reg;
    logic                          out_valid_reg;

    // Working registers
    logic signed [DataWidth-1:0]   tgt_reg;
    logic signed [DataWidth-1:0]   err_reg;
    logic signed [DataWidth:0]     de_reg;
    logic [DataWidth-1:0]          dt_reg;
    logic [ProdWidth-1:0]          prod_reg, prod_next;
    logic                          prod_neg_reg;
    logic [2*DataWidth-1:0]        hi_reg;
    logic signed [TermWidth-1:0]   acc_reg;
    logic [DataWidth-1:0]          rem_reg;
    logic [DivSteps-1:0]           dvd_reg;
    logic [DivSteps-1:0]           quot_reg;
    logic [DivCntWidth-1:0]        div_cnt_reg;
    logic                          div_sat_reg;
    logic                          div_neg_reg;
    logic [PwmWidth-1:0]           pwm_reg, pwm_next;
    logic signed [DataWidth-1:0]   pos_out_reg;
    logic                          clamp_reg, clamp_next;
    logic                          zdt_out_reg;

    logic                          take;
    logic                          out_busy;
    logic [COUNTER_WIDTH+CountWidth-1:0] cnt_wide;
    logic [COUNTER_WIDTH-1:0]      cnt;
    logic [COUNTER_WIDTH-1:0]      cnt_diff;
    logic signed [DataWidth-1:0]   err_w;

    logic [DataWidth-1:0]          err_abs, kp_abs, ki_abs, kd_abs;
    logic [2*DataWidth-1:0]        integ_abs;
    logic [DataWidth:0]            de_abs;
    logic [DataWidth-1:0]          mul_a;
    logic [DataWidth:0]            mul_b;
    logic                          mul_neg;

    logic signed [2*DataWidth:0]   sprod, isum;
    logic [ProdWidth-1:0]          imag;
    logic [ProdWidth-1:0]          dmag;
    logic [DataWidth:0]            trial;
    logic                          trial_ge;
    logic [TermWidth-1:0]          acc_abs;
    logic [DriveWidth-1:0]         drv;
    logic [LimitWidth-1:0]         drv_lim;

    eps_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctl    (ctl)
    );

    assign out_busy            = out_valid_reg && !result.ready;
    assign status.sample_valid = sample.valid;
    assign status.zero_dt      = (dt_reg == '0);
    assign status.div_busy     = (div_cnt_reg != '0);
    assign status.out_busy     = out_busy;

    assign sample.ready = (ctl.op == OP_TAKE);
    assign take         = sample.valid && sample.ready;

    assign result.valid          = out_valid_reg;
    assign result.pwm_compare    = pwm_reg;
    assign result.position_ticks = pos_out_reg;
    assign result.drive_clamped  = clamp_reg;
    assign result.zero_interval  = zdt_out_reg;

    // Count unwrap: modular difference read as signed
    assign cnt_wide = {{COUNTER_WIDTH{1'b0}}, sample.encoder_count};
    assign cnt      = cnt_wide[COUNTER_WIDTH-1:0];
    assign cnt_diff = cnt - last_count_reg;
    assign err_w    = position_reg - tgt_reg;

    always_comb
    begin
        err_abs   = err_reg[DataWidth-1] ? -err_reg : err_reg;
        kp_abs    = kp_reg[DataWidth-1] ? -kp_reg : kp_reg;
        ki_abs    = ki_reg[DataWidth-1] ? -ki_reg : ki_reg;
        kd_abs    = kd_reg[DataWidth-1] ? -kd_reg : kd_reg;
        integ_abs = integ_reg[2*DataWidth-1] ? -integ_reg : integ_reg;
        de_abs    = de_reg[DataWidth] ? -de_reg : de_reg;

        unique case (ctl.msel)
            MUL_E_DT:
            begin
                mul_a   = err_abs;
                mul_b   = {1'b0, dt_reg};
                mul_neg = err_reg[DataWidth-1];
            end
            MUL_P:
            begin
                mul_a   = kp_abs;
                mul_b   = {1'b0, err_abs};
                mul_neg = kp_reg[DataWidth-1] ^ err_reg[DataWidth-1];
            end
            MUL_I_HI:
            begin
                mul_a   = ki_abs;
                mul_b   = {1'b0, integ_abs[2*DataWidth-1:DataWidth]};
                mul_neg = ki_reg[DataWidth-1] ^ integ_reg[2*DataWidth-1];
            end
            MUL_I_LO:
            begin
                mul_a   = ki_abs;
                mul_b   = {1'b0, integ_abs[DataWidth-1:0]};
                mul_neg = ki_reg[DataWidth-1] ^ integ_reg[2*DataWidth-1];
            end
            MUL_D:
            begin
                mul_a   = kd_abs;
                mul_b   = de_abs;
                mul_neg = kd_reg[DataWidth-1] ^ de_reg[DataWidth];
            end
            default:
            begin
                mul_a   = '0;
                mul_b   = '0;
                mul_neg = 1'b0;
            end
        endcase
        prod_next = mul_a * mul_b;
    end

    // Saturating integral update
    always_comb
    begin
        sprod = prod_neg_reg ? -signed'({1'b0, prod_reg[2*DataWidth-1:0]})
                             : signed'({1'b0, prod_reg[2*DataWidth-1:0]});
        isum  = {integ_reg[2*DataWidth-1], integ_reg} + sprod;
        if (isum[2*DataWidth] != isum[2*DataWidth-1])
        begin
            integ_next = isum[2*DataWidth] ? {1'b1, {(2*DataWidth-1){1'b0}}}
                                           : {1'b0, {(2*DataWidth-1){1'b1}}};
        end
        else
        begin
            integ_next = isum[2*DataWidth-1:0];
        end
    end

    // Term magnitudes, divider step and final clamp
    always_comb
    begin
        imag = (hi_reg[2*DataWidth-1:DataWidth-1] != '0)
             ? ProdWidth'(TermSat)
             : ProdWidth'({hi_reg[DataWidth-2:0], {QShift{1'b0}}}) + (prod_reg >> QShift);
        dmag = div_sat_reg ? ProdWidth'(TermSat) : ProdWidth'(quot_reg);

        trial    = {rem_reg, dvd_reg[DivSteps-1]};
        trial_ge = (trial >= {1'b0, dt_reg});

        acc_abs    = acc_reg[TermWidth-1] ? -acc_reg : acc_reg;
        drv        = acc_abs[TermWidth-1:QShift];
        clamp_next = (drv > DriveWidth'(lim_reg));
        drv_lim    = clamp_next ? lim_reg : drv[LimitWidth-1:0];
        pwm_next   = acc_reg[TermWidth-1] ? PwmWidth'(lim_reg) + PwmWidth'(drv_lim)
                                          : PwmWidth'(lim_reg) - PwmWidth'(drv_lim);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg         <= '0;
            ki_reg         <= '0;
            kd_reg         <= '0;
            lim_reg        <= DriveLimitReset;
            last_count_reg <= '0;
            position_reg   <= '0;
            last_time_reg  <= '0;
            integ_reg      <= '0;
            prev_err_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_PROP_GAIN:   kp_reg  <= cfg_data;
                    REG_INTEG_GAIN:  ki_reg  <= cfg_data;
                    REG_DERIV_GAIN:  kd_reg  <= cfg_data;
                    REG_DRIVE_LIMIT: lim_reg <= cfg_data[LimitWidth-1:0];
                    default:         lim_reg <= lim_reg;
                endcase
            end
            if (take)
            begin
                last_count_reg <= cnt;
                position_reg   <= position_reg + DataWidth'(signed'(cnt_diff));
                last_time_reg  <= sample.timestamp_us;
            end
            if (ctl.op == OP_ERROR)
            begin
                prev_err_reg <= err_w;
            end
            if (ctl.op == OP_INTEG)
            begin
                integ_reg <= integ_next;
            end
            if (ctl.op == OP_FINISH && !out_busy)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg     <= prod_next;
        prod_neg_reg <= mul_neg;
        if (take)
        begin
            tgt_reg <= sample.target_position;
            dt_reg  <= sample.timestamp_us - last_time_reg;
        end
        unique case (ctl.op)
            OP_ERROR:
            begin
                err_reg <= err_w;
                de_reg  <= {err_w[DataWidth-1], err_w}
                         - {prev_err_reg[DataWidth-1], prev_err_reg};
            end
            OP_TERM_P:
            begin
                acc_reg <= sat_term(prod_reg, prod_neg_reg);
            end
            OP_SAVE_HI:
            begin
                hi_reg <= prod_reg[2*DataWidth-1:0];
            end
            OP_TERM_I:
            begin
                acc_reg <= acc_reg + sat_term(imag, prod_neg_reg);
            end
            OP_DIV_INIT:
            begin
                // quotient past the term limit when the top bits already reach dt
                div_sat_reg <= (DataWidth'(prod_reg[ProdWidth-1:DivLow]) >= dt_reg);
                rem_reg     <= DataWidth'(prod_reg[ProdWidth-1:DivLow]);
                dvd_reg     <= {prod_reg[DivLow-1:0], {DerivShift{1'b0}}};
                div_cnt_reg <= DivCntWidth'(DivSteps - 1);
                div_neg_reg <= prod_neg_reg;
            end
            OP_DIV_STEP:
            begin
                rem_reg     <= trial_ge ? DataWidth'(trial - {1'b0, dt_reg})
                                        : trial[DataWidth-1:0];
                dvd_reg     <= {dvd_reg[DivSteps-2:0], 1'b0};
                quot_reg    <= {quot_reg[DivSteps-2:0], trial_ge};
                div_cnt_reg <= div_cnt_reg - DivCntWidth'(1);
            end
            OP_TERM_D:
            begin
                acc_reg <= acc_reg + sat_term(dmag, div_neg_reg);
            end
            OP_FINISH:
            begin
                if (!out_busy)
                begin
                    pwm_reg     <= pwm_next;
                    pos_out_reg <= position_reg;
                    clamp_reg   <= clamp_next;
                    zdt_out_reg <= (dt_reg == '0);
                end
            end
            default:
            begin
            end
        endcase
    end

`ifndef SYNTHESIS
    a_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(ctl.op == OP_FINISH))
        else $error("result valid raised outside the finish step");

    a_pwm_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (pwm_reg <= {lim_reg, 1'b0}))
        else $error("compare value beyond twice the limit");

    a_clamp_at_edge: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && clamp_reg) |-> (pwm_reg == '0 || pwm_reg == {lim_reg, 1'b0}))
        else $error("clamped drive not at a limit");

    a_div_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.op == OP_DIV_STEP && div_cnt_reg == '0) |=> (ctl.op == OP_TERM_D))
        else $error("divider did not hand over after its last step");
`endif

endmodule

// File: tb/tb_encoder_position_pid_servo.sv
module tb_encoder_position_pid_servo;
    import eps_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LatencyCycles  = 64;
    localparam int CycleLimit     = 8_000_000;
    localparam int RandomPhases   = 8;
    localparam int RandomPerPhase = 114;
    localparam int MaxStepRun     = 16;
    localparam logic [63:0] TermCap = 64'd1 << TermSatBit;

    typedef struct packed {
        logic [CountWidth-1:0]       encoder_count;
        logic signed [DataWidth-1:0] target_position;
        logic [DataWidth-1:0]        timestamp_us;
    } servo_sample_t;

    typedef struct packed {
        logic [PwmWidth-1:0]         pwm_compare;
        logic signed [DataWidth-1:0] position_ticks;
        logic                        drive_clamped;
        logic                        zero_interval;
    } servo_result_t;

    typedef enum logic {
        ROW_SAMPLE,
        ROW_WRITE
    } row_kind_t;

    typedef struct {
        row_kind_t            kind;
        cfg_reg_t             sel;
        logic [DataWidth-1:0] value;
        servo_sample_t        smp;
        logic                 typed;
        servo_result_t        want;
    } directed_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [CfgIndexWidth-1:0] cfg_index;
    logic [DataWidth-1:0] cfg_data;

    eps_sample_if sample_ch ();
    eps_result_if result_ch ();

    encoder_position_pid_servo dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow copy of the servo registers and tracking state
    logic [DataWidth-1:0]  gain_p;
    logic [DataWidth-1:0]  gain_i;
    logic [DataWidth-1:0]  gain_d;
    logic [LimitWidth-1:0] limit_reg;
    logic [CountWidth-1:0] trk_count;
    logic [DataWidth-1:0]  trk_position;
    logic [DataWidth-1:0]  trk_stamp;
    logic signed [63:0]    trk_integral;
    logic [DataWidth-1:0]  trk_prev_error;

    servo_result_t servo_outputs_due[$];
    directed_row_t directed_rows[$];
    int  mismatches = 0;
    int  cycle_count = 0;
    bit  no_idle = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic logic signed [63:0] sext32(input logic [31:0] v);
        return {{32{v[31]}}, v};
    endfunction

    function automatic logic [63:0] magnitude(input logic signed [63:0] x);
        return x[63] ? 64'd0 - x : x;
    endfunction

    function automatic logic signed [63:0] limit_term(input logic [63:0] mag, input logic neg);
        logic [63:0] capped;
        capped = (mag > TermCap) ? TermCap : mag;
        return neg ? -$signed(capped) : $signed(capped);
    endfunction

    function automatic logic [31:0] pick_gain();
        case ($urandom_range(0, 7))
            0: return 32'd0;
            1: return 32'h8000_0000;
            2: return 32'h7FFF_FFFF;
            3: return $urandom;
            default: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
        endcase
    endfunction

    task automatic predict_servo_output(input servo_sample_t s, output servo_result_t r);
        logic [CountWidth-1:0] step;
        logic [31:0]        e32;
        logic [31:0]        dt;
        logic signed [63:0] err, e_dt, p_full, de, tp, ti, td, sum, drive, lim, span;
        logic signed [64:0] acc;
        logic [63:0]        mag_ki, mag_int, p_hi, p_lo, imag, m, q, rem, dmag, shifted;
        begin
            // Unwrap the count by signed modular difference
            step = s.encoder_count - trk_count;
            trk_position = trk_position + {{(DataWidth-CountWidth){step[CountWidth-1]}}, step};
            trk_count = s.encoder_count;

            e32 = trk_position - s.target_position;
            err = sext32(e32);
            dt = s.timestamp_us - trk_stamp;
            trk_stamp = s.timestamp_us;

            e_dt = err * $signed({32'd0, dt});
            acc = {trk_integral[63], trk_integral} + {e_dt[63], e_dt};
            if (acc[64] != acc[63])
                trk_integral = acc[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
            else
                trk_integral = acc[63:0];

            p_full = sext32(gain_p) * err;
            tp = limit_term(magnitude(p_full), p_full[63]);

            mag_ki = magnitude(sext32(gain_i));
            mag_int = magnitude(trk_integral);
            p_hi = mag_ki * (mag_int >> 32);
            p_lo = mag_ki * {32'd0, mag_int[31:0]};
            imag = (p_hi >= 64'h8000_0000) ? TermCap : (p_hi << QShift) + (p_lo >> QShift);
            ti = limit_term(imag, gain_i[31] ^ trk_integral[63]);

            td = 64'sd0;
            if (dt != 32'd0)
            begin
                de = err - sext32(trk_prev_error);
                m = magnitude(sext32(gain_d)) * magnitude(de);
                q = m / {32'd0, dt};
                rem = m % {32'd0, dt};
                if (q >= (64'd1 << DivLow))
                    dmag = TermCap;
                else
                    dmag = (q << DerivShift) + ((rem << DerivShift) / {32'd0, dt});
                td = limit_term(dmag, gain_d[31] ^ de[63]);
            end
            trk_prev_error = e32;

            // Truncate the Q.16 sum toward zero
            sum = tp + ti + td;
            shifted = magnitude(sum) >> QShift;
            drive = sum[63] ? -$signed(shifted) : $signed(shifted);
            lim = {49'd0, limit_reg};
            r.drive_clamped = 1'b0;
            if (drive > lim)
            begin
                drive = lim;
                r.drive_clamped = 1'b1;
            end
            if (drive < -lim)
            begin
                drive = -lim;
                r.drive_clamped = 1'b1;
            end
            span = lim - drive;
            r.pwm_compare = span[PwmWidth-1:0];
            r.position_ticks = trk_position;
            r.zero_interval = (dt == 32'd0);
        end
    endtask

    task automatic send_sample(input servo_sample_t s, input logic typed, input servo_result_t want);
        int gap;
        servo_result_t r;
        begin
            gap = no_idle ? 0 : $urandom_range(0, 14);
            repeat (gap)
            begin
                @(negedge clk);
                sample_ch.valid <= 1'b0;
            end
            @(negedge clk);
            sample_ch.valid <= 1'b1;
            sample_ch.encoder_count <= s.encoder_count;
            sample_ch.target_position <= s.target_position;
            sample_ch.timestamp_us <= s.timestamp_us;
            do @(posedge clk); while (!(sample_ch.valid && sample_ch.ready));
            predict_servo_output(s, r);
            servo_outputs_due.push_back(typed ? want : r);
        end
    endtask

    // Drop valid, then hold until every result is out and the block has settled
    task automatic wait_drained();
        @(negedge clk);
        sample_ch.valid <= 1'b0;
        while (servo_outputs_due.size() != 0) @(posedge clk);
        repeat (LatencyCycles) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t sel, input logic [DataWidth-1:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= sel;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (sel)
            REG_PROP_GAIN:  gain_p = value;
            REG_INTEG_GAIN: gain_i = value;
            REG_DERIV_GAIN: gain_d = value;
            default:        limit_reg = value[LimitWidth-1:0];
        endcase
    endtask

    task automatic add_write(input cfg_reg_t sel, input logic [DataWidth-1:0] value);
        directed_row_t row;
        row.kind = ROW_WRITE;
        row.sel = sel;
        row.value = value;
        row.smp = '0;
        row.typed = 1'b0;
        row.want = '0;
        directed_rows.push_back(row);
    endtask

    task automatic add_sample(input logic [15:0] cnt, input logic [31:0] tgt, input logic [31:0] ts);
        directed_row_t row;
        row.kind = ROW_SAMPLE;
        row.sel = REG_PROP_GAIN;
        row.value = '0;
        row.smp = '{cnt, tgt, ts};
        row.typed = 1'b0;
        row.want = '0;
        directed_rows.push_back(row);
    endtask

    task automatic add_typed(input logic [15:0] cnt, input logic [31:0] tgt, input logic [31:0] ts,
                             input logic [15:0] pwm, input logic [31:0] pos,
                             input logic clamp, input logic zero);
        directed_row_t row;
        row.kind = ROW_SAMPLE;
        row.sel = REG_PROP_GAIN;
        row.value = '0;
        row.smp = '{cnt, tgt, ts};
        row.typed = 1'b1;
        row.want = '{pwm, pos, clamp, zero};
        directed_rows.push_back(row);
    endtask

    // Result side: random stalls, check each word against the oldest prediction
    initial
    begin
        int stall;
        servo_result_t got;
        servo_result_t want;
        result_ch.ready = 1'b0;
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 14);
            repeat (stall)
            begin
                @(negedge clk);
                result_ch.ready <= 1'b0;
            end
            @(negedge clk);
            result_ch.ready <= 1'b1;
            do @(posedge clk); while (!(result_ch.valid && result_ch.ready));
            got = '{result_ch.pwm_compare, result_ch.position_ticks,
                    result_ch.drive_clamped, result_ch.zero_interval};
            if (servo_outputs_due.size() == 0)
            begin
                $display("%0t: unexpected word: expected none, actual pwm %0d pos %0d %s",
                         $time, got.pwm_compare, got.position_ticks,
                         $sformatf("clamp %0b zero %0b", got.drive_clamped, got.zero_interval));
                mismatches++;
            end
            else
            begin
                want = servo_outputs_due.pop_front();
                if (got !== want)
                begin
                    $display("%0t: expected pwm %0d pos %0d clamp %0b zero %0b, %s",
                             $time, want.pwm_compare, want.position_ticks, want.drive_clamped,
                             want.zero_interval,
                             $sformatf("actual pwm %0d pos %0d clamp %0b zero %0b",
                                       got.pwm_compare, got.position_ticks,
                                       got.drive_clamped, got.zero_interval));
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        servo_sample_t s;
        servo_result_t none;
        logic [31:0] value;

        none = '0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_PROP_GAIN;
        cfg_data = '0;
        sample_ch.valid = 1'b0;
        sample_ch.encoder_count = '0;
        sample_ch.target_position = '0;
        sample_ch.timestamp_us = '0;
        gain_p = '0;
        gain_i = '0;
        gain_d = '0;
        limit_reg = DriveLimitReset;
        trk_count = '0;
        trk_position = '0;
        trk_stamp = '0;
        trk_integral = '0;
        trk_prev_error = '0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Zero gains after reset: drive stays 0, position follows the count
        add_typed(16'h0000, 32'h0000_0000, 32'h0000_0000, 16'd500, 32'd0, 1'b0, 1'b1);
        add_typed(16'h7FFF, 32'h7FFF_FFFF, 32'd10, 16'd500, 32'd32767, 1'b0, 1'b0);
        // half-range forward step reads as backward
        add_typed(16'hFFFF, 32'h8000_0000, 32'd10, 16'd500, 32'hFFFF_FFFF, 1'b0, 1'b1);
        add_typed(16'h0000, 32'h0000_0000, 32'd20, 16'd500, 32'd0, 1'b0, 1'b0);
        add_typed(16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd500, 32'hFFFF_FFFF, 1'b0, 1'b0);
        add_typed(16'h0000, 32'd12345, 32'h0000_0000, 16'd500, 32'd0, 1'b0, 1'b0);
        // unit proportional gain
        add_write(REG_PROP_GAIN, 32'h0001_0000);
        add_typed(16'h0000, -32'sd100, 32'd1, 16'd400, 32'd0, 1'b0, 1'b0);
        add_typed(16'h0000, -32'sd1000, 32'd2, 16'd0, 32'd0, 1'b1, 1'b0);
        add_typed(16'h0000, 32'd1000, 32'd3, 16'd1000, 32'd0, 1'b1, 1'b0);
        add_typed(16'h0000, 32'd0, 32'd3, 16'd500, 32'd0, 1'b0, 1'b1);
        // error wraps past the 32-bit range
        add_write(REG_DRIVE_LIMIT, 32'd32767);
        add_write(REG_PROP_GAIN, 32'h8000_0000);
        add_sample(16'h0000, 32'h8000_0000, 32'd100);
        add_sample(16'h8000, 32'h7FFF_FFFF, 32'd100);
        // drive the integral into both saturation limits
        add_write(REG_PROP_GAIN, 32'h7FFF_FFFF);
        add_write(REG_INTEG_GAIN, 32'h7FFF_FFFF);
        add_write(REG_DERIV_GAIN, 32'h7FFF_FFFF);
        add_sample(16'h8000, 32'h8000_8000, 32'hF000_0000);
        add_sample(16'h8000, 32'h8000_8000, 32'hE000_0000);
        add_sample(16'h8000, 32'h8000_8000, 32'hD000_0000);
        add_sample(16'h8000, 32'h7FFF_7FFF, 32'hC000_0000);
        add_sample(16'h8000, 32'h7FFF_7FFF, 32'hB000_0000);
        add_sample(16'h8000, 32'h7FFF_7FFF, 32'hA000_0000);
        add_write(REG_DRIVE_LIMIT, 32'd1);
        add_sample(16'h8000, 32'd0, 32'hA000_0001);
        add_write(REG_DRIVE_LIMIT, 32'd0);
        add_sample(16'h8000, 32'd0, 32'hA000_0002);
        add_write(REG_DERIV_GAIN, 32'h8000_0000);
        add_write(REG_INTEG_GAIN, 32'h8000_0000);
        add_write(REG_DRIVE_LIMIT, 32'd500);
        add_sample(16'h8000, 32'h7FFF_FFFF, 32'hA000_0003);
        add_sample(16'h0000, 32'd5, 32'hA000_0003);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_WRITE)
            begin
                wait_drained();
                write_reg(directed_rows[i].sel, directed_rows[i].value);
            end
            else
                send_sample(directed_rows[i].smp, directed_rows[i].typed, directed_rows[i].want);
        end

        // Step forward by the largest positive delta, back to back
        wait_drained();
        write_reg(REG_PROP_GAIN, pick_gain());
        write_reg(REG_INTEG_GAIN, pick_gain());
        write_reg(REG_DERIV_GAIN, pick_gain());
        write_reg(REG_DRIVE_LIMIT, $urandom_range(1, 32767));
        no_idle = 1'b1;
        for (int k = 0; k < MaxStepRun; k++)
        begin
            s.encoder_count = trk_count + 16'h7FFF;
            s.target_position = $urandom;
            s.timestamp_us = trk_stamp;
            send_sample(s, 1'b0, none);
        end
        no_idle = 1'b0;

        for (int p = 0; p < RandomPhases; p++)
        begin
            wait_drained();
            write_reg(REG_PROP_GAIN, pick_gain());
            write_reg(REG_INTEG_GAIN, pick_gain());
            write_reg(REG_DERIV_GAIN, pick_gain());
            if (p == 0)
                value = 32'd1;
            else if (p == 1)
                value = 32'd32767;
            else
                case ($urandom_range(0, 4))
                    0: value = 32'd500;
                    1: value = 32'd1;
                    2: value = 32'd32767;
                    default: value = $urandom_range(1, 32767);
                endcase
            write_reg(REG_DRIVE_LIMIT, value);
            no_idle = (p == 5);

            for (int n = 0; n < RandomPerPhase; n++)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5:
                        s.encoder_count = trk_count - 16'd200
                                        + CountWidth'($urandom_range(0, 400));
                    6: s.encoder_count = trk_count + 16'h7FFF;
                    7: s.encoder_count = trk_count + 16'h8000;
                    8: s.encoder_count = CountWidth'($urandom);
                    default: s.encoder_count = trk_count;
                endcase
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5, 6:
                        s.target_position = trk_position - 32'd1000 + $urandom_range(0, 2000);
                    7: s.target_position = $urandom;
                    8: s.target_position = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
                    default: s.target_position = trk_position;
                endcase
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: s.timestamp_us = trk_stamp + $urandom_range(1, 2000);
                    6: s.timestamp_us = trk_stamp;
                    7: s.timestamp_us = $urandom;
                    8: s.timestamp_us = trk_stamp + 32'd1;
                    default: s.timestamp_us = trk_stamp + $urandom_range(100000, 3000000);
                endcase
                send_sample(s, 1'b0, none);
                // hold the sender mid-phase until the pipe is empty
                if (n == RandomPerPhase / 2)
                    wait_drained();
            end
            no_idle = 1'b0;
        end

        wait_drained();
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/eps_pkg.sv
rtl/core/eps_sample_if.sv
rtl/core/eps_result_if.sv
rtl/core/eps_seq.sv
rtl/core/encoder_position_pid_servo.sv
tb/tb_encoder_position_pid_servo.sv
